### hdl/rce_pkg.sv
// ----------------------------------------------------------------------------
// Rotary encoder click decoder package
// Shared types, request kinds, event codes and sizes for the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rce_pkg;

   localparam int HOLD_TICKS = 2;
   localparam int POS_WIDTH  = 32;
   localparam int HOLD_W     = $clog2(HOLD_TICKS + 1);
   localparam int THR_W      = 16;
   localparam int POS_OUT_W  = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic [THR_W-1:0] THR_RESET = 16'd100;
   localparam logic [THR_W-1:0] THR_MAX   = 16'd65534;

   localparam logic [1:0] KIND_TICK = 2'd0;
   localparam logic [1:0] KIND_EDGE = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;
   localparam logic [1:0] KIND_SET  = 2'd3;

   localparam logic [2:0] EV_NONE  = 3'd0;
   localparam logic [2:0] EV_CW    = 3'd1;
   localparam logic [2:0] EV_CCW   = 3'd2;
   localparam logic [2:0] EV_CLICK = 3'd3;
   localparam logic [2:0] EV_LONG  = 3'd4;

   // sticky flag bit positions
   localparam int F_CLICK = 0;
   localparam int F_MOVED = 1;
   localparam int F_LONG  = 2;
   localparam int F_CW    = 3;
   localparam int F_CCW   = 4;

   typedef struct packed {
      logic [1:0]           kind;
      logic                 pin_a;
      logic                 pin_b;
      logic                 pin_push;
      logic [POS_OUT_W-1:0] new_position;
   } req_item_type;

   typedef struct packed {
      logic                 event_posted;
      logic                 read_ok;
      logic [POS_OUT_W-1:0] position;
      logic [4:0]           flags;
      logic [2:0]           last_event;
   } rsp_item_type;

endpackage

`default_nettype wire

### hdl/rce_core.sv
// ----------------------------------------------------------------------------
// Rotary encoder decoder core
// Holds pin samples, button timer, position and sticky events; applies one
// request word per step and forms its response word.
// ----------------------------------------------------------------------------
`default_nettype none

module rce_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire rce_pkg::req_item_type       item,
   input  wire logic [rce_pkg::THR_W-1:0]   long_click_ticks,
   output      rce_pkg::rsp_item_type       result
);
   import rce_pkg::*;

   logic                  cur_a_ff, cur_b_ff, cur_pressed_ff;
   logic                  prev_a_ff, prev_b_ff, prev_pressed_ff;
   logic [THR_W-1:0]      press_ticks_ff;
   logic [HOLD_W-1:0]     hold_ticks_ff;
   logic [POS_WIDTH-1:0]  pos_count_ff;
   logic [4:0]            sticky_ff;
   logic [2:0]            event_code_ff;
   logic                  unread_ff;

   logic                  cur_a_in, cur_b_in, cur_pressed_in;
   logic                  prev_a_in, prev_b_in, prev_pressed_in;
   logic [THR_W-1:0]      press_ticks_in;
   logic [HOLD_W-1:0]     hold_ticks_in;
   logic [POS_WIDTH-1:0]  pos_count_in;
   logic [4:0]            sticky_in;
   logic [2:0]            event_code_in;
   logic                  unread_in;

   logic [THR_W-1:0]      thr;
   logic                  sa, sb, sp;
   logic                  fresh;

   always_comb begin
      thr = (long_click_ticks > THR_MAX) ? THR_MAX : long_click_ticks;

      cur_a_in        = cur_a_ff;
      cur_b_in        = cur_b_ff;
      cur_pressed_in  = cur_pressed_ff;
      prev_a_in       = prev_a_ff;
      prev_b_in       = prev_b_ff;
      prev_pressed_in = prev_pressed_ff;
      press_ticks_in  = press_ticks_ff;
      hold_ticks_in   = hold_ticks_ff;
      pos_count_in    = pos_count_ff;
      sticky_in       = sticky_ff;
      event_code_in   = event_code_ff;
      unread_in       = unread_ff;

      result.event_posted = 1'b0;
      result.read_ok      = 1'b0;
      result.flags        = '0;
      result.last_event   = EV_NONE;

      sa    = cur_a_ff;
      sb    = cur_b_ff;
      sp    = cur_pressed_ff;
      fresh = 1'b0;

      unique case (item.kind)
         KIND_TICK: begin
            if (hold_ticks_ff != '0) begin
               hold_ticks_in = hold_ticks_ff - HOLD_W'(1);
            end else begin
               sa = item.pin_a;
               sb = item.pin_b;
               sp = ~item.pin_push;
            end

            if (!sa && prev_a_ff && sb) begin
               pos_count_in = pos_count_ff + POS_WIDTH'(1);
               sticky_in[F_MOVED] = 1'b1;
               sticky_in[F_CW]    = 1'b1;
               event_code_in      = EV_CW;
               fresh              = 1'b1;
            end
            if (!sb && prev_b_ff && sa) begin
               pos_count_in = pos_count_ff - POS_WIDTH'(1);
               sticky_in[F_MOVED] = 1'b1;
               sticky_in[F_CCW]   = 1'b1;
               event_code_in      = EV_CCW;
               fresh              = 1'b1;
            end

            priority if (sp && !prev_pressed_ff) begin
               press_ticks_in = '0;
            end else if (sp && prev_pressed_ff && press_ticks_ff < thr) begin
               press_ticks_in = press_ticks_ff + THR_W'(1);
            end else if (sp && prev_pressed_ff && press_ticks_ff == thr) begin
               press_ticks_in    = press_ticks_ff + THR_W'(1);
               sticky_in[F_LONG] = 1'b1;
               event_code_in     = EV_LONG;
               fresh             = 1'b1;
            end else if (!sp && prev_pressed_ff && press_ticks_ff < thr) begin
               sticky_in[F_CLICK] = 1'b1;
               event_code_in      = EV_CLICK;
               fresh              = 1'b1;
            end else begin
               press_ticks_in = press_ticks_ff;
            end

            if (fresh) begin
               unread_in = 1'b1;
            end
            result.event_posted = fresh;
            cur_a_in        = sa;
            cur_b_in        = sb;
            cur_pressed_in  = sp;
            prev_a_in       = sa;
            prev_b_in       = sb;
            prev_pressed_in = sp;
         end
         KIND_EDGE: begin
            if (hold_ticks_ff == '0) begin
               hold_ticks_in  = HOLD_W'(HOLD_TICKS);
               cur_a_in       = item.pin_a;
               cur_b_in       = item.pin_b;
               cur_pressed_in = ~item.pin_push;
            end
         end
         KIND_READ: begin
            if (unread_ff) begin
               result.read_ok    = 1'b1;
               result.flags      = sticky_ff;
               result.last_event = event_code_ff;
               sticky_in         = '0;
               event_code_in     = EV_NONE;
               unread_in         = 1'b0;
            end
         end
         KIND_SET: begin
            pos_count_in = item.new_position[POS_WIDTH-1:0];
         end
         default: begin
            pos_count_in = pos_count_ff;
         end
      endcase

      result.position = POS_OUT_W'(pos_count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_a_ff        <= 1'b1;
         cur_b_ff        <= 1'b1;
         cur_pressed_ff  <= 1'b0;
         prev_a_ff       <= 1'b1;
         prev_b_ff       <= 1'b1;
         prev_pressed_ff <= 1'b0;
         press_ticks_ff  <= '0;
         hold_ticks_ff   <= '0;
         pos_count_ff    <= '0;
         sticky_ff       <= '0;
         event_code_ff   <= EV_NONE;
         unread_ff       <= 1'b0;
      end else if (step) begin
         cur_a_ff        <= cur_a_in;
         cur_b_ff        <= cur_b_in;
         cur_pressed_ff  <= cur_pressed_in;
         prev_a_ff       <= prev_a_in;
         prev_b_ff       <= prev_b_in;
         prev_pressed_ff <= prev_pressed_in;
         press_ticks_ff  <= press_ticks_in;
         hold_ticks_ff   <= hold_ticks_in;
         pos_count_ff    <= pos_count_in;
         sticky_ff       <= sticky_in;
         event_code_ff   <= event_code_in;
         unread_ff       <= unread_in;
      end
   end

endmodule

`default_nettype wire

### hdl/rotary_encoder_click_decoder.sv
// ----------------------------------------------------------------------------
// Rotary encoder click decoder
// Quadrature decoder with push-button click and long-click timing, sticky
// event flags, read-and-clear and position load.
//
// Path: the input register takes the word at the accept edge; the core's single
//   pass fills the response register and its valid when the stages advance,
//   which a held response waiting on rsp_tready can delay.
// Throughput: one word per cycle; the stages stall together on rsp_tready.
// Reset: synchronous; clears samples, timers, position, flags and both stage
//   valids; long_click_ticks returns to 100.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_encoder_click_decoder (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // tdata: pin_a, pin_b, pin_push, new_position[31:0], zero pad
   input  wire logic [rce_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: req_type[1:0]
   input  wire logic [1:0]                         req_tuser,
   // response channel
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // tdata: position[31:0], click_seen, moved_seen, long_click_seen,
   //        moved_cw_seen, moved_ccw_seen, last_event[2:0]
   output      logic [rce_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser: event_posted, read_ok
   output      logic [1:0]                         rsp_tuser,
   // configuration: long_click_ticks
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [rce_pkg::THR_W-1:0]          csr_data
);
   import rce_pkg::*;

   logic [THR_W-1:0] thr_ff;
   logic             in_valid_ff;
   req_item_type     in_item_ff;
   logic             out_valid_ff;
   rsp_item_type     out_item_ff;

   rsp_item_type     core_result;
   logic             advance;
   logic             step;

   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.kind         <= req_tuser;
         in_item_ff.pin_a        <= req_tdata[0];
         in_item_ff.pin_b        <= req_tdata[1];
         in_item_ff.pin_push     <= req_tdata[2];
         in_item_ff.new_position <= req_tdata[POS_OUT_W+2:3];
      end
   end

   rce_core u_core (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .item             (in_item_ff),
      .long_click_ticks (thr_ff),
      .result           (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {out_item_ff.read_ok, out_item_ff.event_posted};
   assign rsp_tdata  = {out_item_ff.last_event, out_item_ff.flags, out_item_ff.position};

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder click decoder testbench
// Walks a short table of hand-picked words, then streams randomized encoder
// traffic (quadrature walks, button presses around the long-click threshold,
// interrupt samples, reads and position loads) under several thresholds with
// random sender gaps, receiver stalls and one long hold-off. Typed table rows
// are checked field by field against their words, others an in-bench model.
// ----------------------------------------------------------------------------

module tb;
   import rce_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD_WORDS = 40;

   typedef struct packed {
      logic [1:0]  kind;
      logic        pin_a;
      logic        pin_b;
      logic        pin_push;
      logic [31:0] load;
      bit          typed;
      logic        posted;
      logic        ok;
      logic [31:0] pos;
      logic [4:0]  flags;
      logic [2:0]  ev;
   } script_row_type;

   localparam logic [4:0] FL_CW = 5'((1 << F_MOVED) | (1 << F_CW));

   localparam int SCRIPT_LEN = 21;
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      '{KIND_READ, 1'b0, 1'b0, 1'b0, 32'h0,        1'b1, 1'b0, 1'b0, 32'h0,        5'h0, EV_NONE},
      '{KIND_SET,  1'b0, 1'b1, 1'b0, 32'hFFFFFFFF, 1'b1, 1'b0, 1'b0, 32'hFFFFFFFF, 5'h0, EV_NONE},
      '{KIND_TICK, 1'b1, 1'b1, 1'b1, 32'hFFFFFFFF, 1'b1, 1'b0, 1'b0, 32'hFFFFFFFF, 5'h0, EV_NONE},
      '{KIND_TICK, 1'b0, 1'b1, 1'b1, 32'h0,        1'b1, 1'b1, 1'b0, 32'h0,        5'h0, EV_NONE},
      '{KIND_READ, 1'b1, 1'b1, 1'b0, 32'h5A5A5A5A, 1'b1, 1'b0, 1'b1, 32'h0,        FL_CW, EV_CW},
      '{KIND_READ, 1'b0, 1'b0, 1'b1, 32'hA5A5A5A5, 1'b1, 1'b0, 1'b0, 32'h0,        5'h0, EV_NONE},
      '{KIND_TICK, 1'b1, 1'b1, 1'b1, 32'h0,        1'b1, 1'b0, 1'b0, 32'h0,        5'h0, EV_NONE},
      '{KIND_TICK, 1'b1, 1'b0, 1'b1, 32'h12345678, 1'b1, 1'b1, 1'b0, 32'hFFFFFFFF, 5'h0, EV_NONE},
      '{KIND_TICK, 1'b0, 1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0, 32'h0,        5'h0, EV_NONE},
      '{KIND_TICK, 1'b1, 1'b1, 1'b1, 32'h0,        1'b0, 1'b0, 1'b0, 32'h0,        5'h0, EV_NONE},
      '{KIND_READ, 1'b0, 1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0, 32'h0,        5'h0, EV_NONE},
      '{KIND_EDGE, 1'b0, 1'b1, 1'b1, 32'h0,        1'b0, 1'b0, 1'b0, 32'h0,        5'h0, EV_NONE},
      '{KIND_EDGE, 1'b1, 1'b1, 1'b0, 32'hFFFFFFFF, 1'b0, 1'b0, 1'b0, 32'h0,        5'h0, EV_NONE},
      '{KIND_TICK, 1'b1, 1'b1, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0, 32'h0,        5'h0, EV_NONE},
      '{KIND_TICK, 1'b1, 1'b1, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0, 32'h0,        5'h0, EV_NONE},
      '{KIND_TICK, 1'b1, 1'b1, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0, 32'h0,        5'h0, EV_NONE},
      '{KIND_SET,  1'b1, 1'b0, 1'b1, 32'h0,        1'b1, 1'b0, 1'b0, 32'h0,        5'h0, EV_NONE},
      '{KIND_SET,  1'b0, 1'b1, 1'b0, 32'h80000000, 1'b1, 1'b0, 1'b0, 32'h80000000, 5'h0, EV_NONE},
      '{KIND_READ, 1'b1, 1'b1, 1'b1, 32'h0,        1'b0, 1'b0, 1'b0, 32'h0,        5'h0, EV_NONE},
      '{KIND_TICK, 1'b1, 1'b1, 1'b1, 32'h0,        1'b0, 1'b0, 1'b0, 32'h0,        5'h0, EV_NONE},
      '{KIND_READ, 1'b0, 1'b1, 1'b1, 32'h0,        1'b0, 1'b0, 1'b0, 32'h0,        5'h0, EV_NONE}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = KIND_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [THR_W-1:0]      csr_data = '0;

   rotary_encoder_click_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // decoder model state
   logic [THR_W-1:0]  long_thr = THR_RESET;
   logic              smp_a = 1'b1, smp_b = 1'b1, smp_pressed = 1'b0;
   logic              old_a = 1'b1, old_b = 1'b1, old_pressed = 1'b0;
   logic [THR_W-1:0]  press_cnt = '0;
   logic [HOLD_W-1:0] hold_cnt = '0;
   logic [31:0]       pos_cnt = '0;
   logic [4:0]        sticky = '0;
   logic [2:0]        last_ev = EV_NONE;
   bit                unread = 1'b0;

   rsp_item_type due_rsp[$];
   int errors = 0;
   int words_sent = 0;
   int rsp_checked = 0;
   int n_cw = 0, n_ccw = 0, n_click = 0, n_long = 0, n_reads = 0;

   // stimulus generator state
   int burst_left = 0;
   int gen_q = 0;
   bit gen_cw = 1'b1;
   int press_left = 0;

   int stall_left = 0;
   bit squeeze_done = 1'b0;
   logic [15:0] rx_cycle = '0;
   int idle_cycles = 0;

   task automatic decode_word(input req_item_type w, output rsp_item_type r);
      logic [THR_W-1:0] thr;
      bit fresh;
      r = '0;
      fresh = 1'b0;
      case (w.kind)
         KIND_TICK: begin
            thr = (long_thr > THR_MAX) ? THR_MAX : long_thr;
            if (hold_cnt != 0) begin
               hold_cnt = hold_cnt - 1'b1;
            end else begin
               smp_a = w.pin_a;
               smp_b = w.pin_b;
               smp_pressed = !w.pin_push;
            end
            if (!smp_a && old_a && smp_b) begin
               pos_cnt = pos_cnt + 1;
               sticky[F_MOVED] = 1'b1;
               sticky[F_CW] = 1'b1;
               last_ev = EV_CW;
               fresh = 1'b1;
               n_cw++;
            end
            if (!smp_b && old_b && smp_a) begin
               pos_cnt = pos_cnt - 1;
               sticky[F_MOVED] = 1'b1;
               sticky[F_CCW] = 1'b1;
               last_ev = EV_CCW;
               fresh = 1'b1;
               n_ccw++;
            end
            if (smp_pressed && !old_pressed) begin
               press_cnt = '0;
            end else if (smp_pressed && old_pressed && press_cnt < thr) begin
               press_cnt = press_cnt + 1'b1;
            end else if (smp_pressed && old_pressed && press_cnt == thr) begin
               press_cnt = press_cnt + 1'b1;
               sticky[F_LONG] = 1'b1;
               last_ev = EV_LONG;
               fresh = 1'b1;
               n_long++;
            end else if (!smp_pressed && old_pressed && press_cnt < thr) begin
               sticky[F_CLICK] = 1'b1;
               last_ev = EV_CLICK;
               fresh = 1'b1;
               n_click++;
            end
            if (fresh) begin
               unread = 1'b1;
               r.event_posted = 1'b1;
            end
            old_a = smp_a;
            old_b = smp_b;
            old_pressed = smp_pressed;
         end
         KIND_EDGE: begin
            if (hold_cnt == 0) begin
               hold_cnt = HOLD_W'(HOLD_TICKS);
               smp_a = w.pin_a;
               smp_b = w.pin_b;
               smp_pressed = !w.pin_push;
            end
         end
         KIND_READ: begin
            if (unread) begin
               r.read_ok = 1'b1;
               r.flags = sticky;
               r.last_event = last_ev;
               sticky = '0;
               last_ev = EV_NONE;
               unread = 1'b0;
               n_reads++;
            end
         end
         default: pos_cnt = w.new_position;
      endcase
      r.position = pos_cnt;
   endtask

   // offer one word with burst pacing; predict it once it is taken
   task automatic send_word(input req_item_type w, input bit typed, input rsp_item_type typed_rsp);
      rsp_item_type p;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 48);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, w.new_position, w.pin_push, w.pin_b, w.pin_a};
      req_tuser  <= w.kind;
      do @(posedge clock); while (!req_tready);
      decode_word(w, p);
      due_rsp.push_back(typed ? typed_rsp : p);
      words_sent++;
   endtask

   task automatic set_threshold(input logic [THR_W-1:0] v);
      req_tvalid <= 1'b0;
      while (due_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      long_thr = v;
      csr_valid <= 1'b0;
   endtask

   task automatic next_random_word(output req_item_type w, input int hint);
      int pick;
      w.kind = KIND_TICK;
      w.pin_a = 1'($urandom);
      w.pin_b = 1'($urandom);
      w.pin_push = 1'($urandom);
      w.new_position = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         w.kind = KIND_READ;
      end else if (pick < 19) begin
         w.kind = KIND_SET;
         case ($urandom_range(0, 3))
            0: w.new_position = '0;
            1: w.new_position = '1;
            default: ;
         endcase
      end else if (pick < 24) begin
         w.kind = 2'($urandom_range(0, 3));
      end else begin
         if ($urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 9) == 0) gen_cw = !gen_cw;
            gen_q = (gen_q + (gen_cw ? 1 : 3)) % 4;
         end
         if (press_left == 0 && $urandom_range(0, 24) == 0) begin
            case ($urandom_range(0, 4))
               0: press_left = hint;
               1: press_left = hint + 1;
               2: press_left = hint + 2;
               3: press_left = hint + 3 + $urandom_range(0, 5);
               default: press_left = $urandom_range(1, hint + 3);
            endcase
         end
         case (gen_q)
            0: {w.pin_a, w.pin_b} = 2'b11;
            1: {w.pin_a, w.pin_b} = 2'b01;
            2: {w.pin_a, w.pin_b} = 2'b00;
            default: {w.pin_a, w.pin_b} = 2'b10;
         endcase
         w.pin_push = (press_left == 0);
         w.kind = ($urandom_range(0, 11) == 0) ? KIND_EDGE : KIND_TICK;
         if (press_left > 0 && w.kind == KIND_TICK) press_left--;
      end
   endtask

   task automatic run_random(input int count, input int hint);
      req_item_type w;
      for (int i = 0; i < count; i++) begin
         next_random_word(w, hint);
         send_word(w, 1'b0, '0);
      end
   endtask

   // receiver: own stall pattern, plus one long hold-off
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1'b1;
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!squeeze_done && words_sent >= 300) begin
         squeeze_done <= 1'b1;
         stall_left <= 400;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_cycle[11:9])
            3'd0, 3'd1: rsp_tready <= 1'b1;
            3'd6, 3'd7: rsp_tready <= (rx_cycle % 5) < 3;
            default: rsp_tready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (due_rsp.size() == 0) begin
            $display("%0t: unexpected response word, expected none, actual tdata %h tuser %h",
                     $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            want = due_rsp.pop_front();
            check_field("event_posted", want.event_posted, rsp_tuser[0]);
            check_field("read_ok", want.read_ok, rsp_tuser[1]);
            check_field("position", want.position, rsp_tdata[31:0]);
            check_field("click_seen", want.flags[F_CLICK], rsp_tdata[32 + F_CLICK]);
            check_field("moved_seen", want.flags[F_MOVED], rsp_tdata[32 + F_MOVED]);
            check_field("long_click_seen", want.flags[F_LONG], rsp_tdata[32 + F_LONG]);
            check_field("moved_cw_seen", want.flags[F_CW], rsp_tdata[32 + F_CW]);
            check_field("moved_ccw_seen", want.flags[F_CCW], rsp_tdata[32 + F_CCW]);
            check_field("last_event", want.last_event, rsp_tdata[39:37]);
            rsp_checked++;
         end
      end
   end

   // watchdog: count cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d responses outstanding", $time, due_rsp.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      req_item_type w;
      rsp_item_type r;
      int thr_rand;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < SCRIPT_LEN; i++) begin
         w.kind = SCRIPT[i].kind;
         w.pin_a = SCRIPT[i].pin_a;
         w.pin_b = SCRIPT[i].pin_b;
         w.pin_push = SCRIPT[i].pin_push;
         w.new_position = SCRIPT[i].load;
         r.event_posted = SCRIPT[i].posted;
         r.read_ok = SCRIPT[i].ok;
         r.position = SCRIPT[i].pos;
         r.flags = SCRIPT[i].flags;
         r.last_event = SCRIPT[i].ev;
         send_word(w, SCRIPT[i].typed, r);
      end
      run_random(500, THR_RESET);

      set_threshold(16'd1);
      run_random(300, 1);
      set_threshold(16'd0);
      run_random(200, 0);

      // saturated threshold: hold the button a while, release, then read
      set_threshold(16'hFFFF);
      for (int i = 0; i < LONG_HOLD_WORDS + 2; i++) begin
         w.kind = (i == LONG_HOLD_WORDS + 1) ? KIND_READ : KIND_TICK;
         w.pin_a = 1'b1;
         w.pin_b = 1'b1;
         w.pin_push = (i == LONG_HOLD_WORDS);
         w.new_position = $urandom;
         send_word(w, 1'b0, '0);
      end
      run_random(100, 20);

      set_threshold(THR_MAX);
      run_random(200, 20);
      thr_rand = $urandom_range(2, 40);
      set_threshold(THR_W'(thr_rand));
      run_random(400, thr_rand);
      set_threshold(16'd12);
      run_random(300, 12);

      req_tvalid <= 1'b0;
      while (due_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d words, checked %0d responses; thresholds 100, 1, 0, 65535, 65534, %0d, 12",
               words_sent, rsp_checked, thr_rand);
      $display("Events: %0d cw, %0d ccw, %0d clicks, %0d long clicks, %0d successful reads",
               n_cw, n_ccw, n_click, n_long, n_reads);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
